@@ rtl/core/lrupr_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared sizes, register codes and the structs that travel along the row of
// frame cells and from the controller back to the cells.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;

  localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int SLOT_W  = 4;
  localparam int FAULT_W = 16;

  localparam int FRAMES_W = 5;
  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd4;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register index, taken from the word address of the configuration port.
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Search request as it moves from cell to cell.
  typedef struct packed {
    logic                 tok;
    logic [PAGE_BITS-1:0] page;
    logic                 found;
    logic [IDX_W-1:0]     found_idx;
    logic [RANK_W-1:0]    found_rank;
    logic                 empty_found;
    logic [IDX_W-1:0]     empty_idx;
    logic [RANK_W-1:0]    empty_rank;
    logic                 best_found;
    logic [IDX_W-1:0]     best_idx;
    logic [RANK_W-1:0]    best_rank;
    logic [PAGE_BITS-1:0] best_page;
  } chain_t;

  // Update broadcast to every cell once the frame is chosen.
  typedef struct packed {
    logic                 en;
    logic                 fill;
    logic [IDX_W-1:0]     slot;
    logic [RANK_W-1:0]    rank;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

endpackage

@@ rtl/core/lrupr_cell.sv @@
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one frame (page, valid, recency rank), folds its frame into the
// search request passing by and applies the replacement update.
// ----------------------------------------------------------------------------
module lrupr_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lrupr_pkg::IDX_W-1:0]    idx_i,
  input  logic [lrupr_pkg::CNT_W-1:0]    n_act_i,
  input  lrupr_pkg::chain_t              chain_i,
  output lrupr_pkg::chain_t              chain_o,
  input  lrupr_pkg::upd_t                upd_i
);

  logic [lrupr_pkg::PAGE_BITS-1:0] page_q;
  logic                            valid_q;
  logic [lrupr_pkg::RANK_W-1:0]    rank_q;
  lrupr_pkg::chain_t               chain_d;
  lrupr_pkg::chain_t               chain_q;
  logic                            active;

  assign active = (32'(idx_i) < 32'(n_act_i));

  always_comb begin
    chain_d = chain_i;
    if (chain_i.tok && active) begin
      // The first match wins, so a page left in two frames hits the lower one.
      if (valid_q && page_q == chain_i.page && !chain_i.found) begin
        chain_d.found      = 1'b1;
        chain_d.found_idx  = idx_i;
        chain_d.found_rank = rank_q;
      end
      if (!valid_q && !chain_i.empty_found) begin
        chain_d.empty_found = 1'b1;
        chain_d.empty_idx   = idx_i;
        chain_d.empty_rank  = rank_q;
      end
      if (valid_q && (!chain_i.best_found || rank_q > chain_i.best_rank)) begin
        chain_d.best_found = 1'b1;
        chain_d.best_idx   = idx_i;
        chain_d.best_rank  = rank_q;
        chain_d.best_page  = page_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else begin
      chain_q <= chain_d;
    end
  end

  assign chain_o = chain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= idx_i;
    end else if (upd_i.en) begin
      if (upd_i.slot == idx_i) begin
        rank_q <= '0;
        if (upd_i.fill) begin
          valid_q <= 1'b1;
        end
      end else if (rank_q < upd_i.rank) begin
        rank_q <= rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en && upd_i.fill && upd_i.slot == idx_i) begin
      page_q <= upd_i.page;
    end
  end

endmodule

@@ rtl/core/lru_page_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Fully associative LRU frame set built as a row of frame cells.
// ----------------------------------------------------------------------------
// One page reference is handled at a time: the first cell registers the
// reference at the accepting edge and it walks on through the row one cell per
// cycle, collecting the hit frame, the lowest empty frame and the oldest
// frame; then the outcome is captured in a result register, and the update
// writes the frame, ages the ranks in every cell at once and registers the
// result. The next reference is taken only once that update is done, even
// while the previous result still waits in the output register. A result that
// is still waiting when the next reference reaches its update holds that
// reference until it is taken.
module lru_page_replacement_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lrupr_pkg::ADDR_W-1:0]        paddr,
  input  logic [lrupr_pkg::DATA_W-1:0]        pwdata,
  output logic [lrupr_pkg::DATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lrupr_pkg::PAGE_BITS-1:0]     page_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic [lrupr_pkg::SLOT_W-1:0]        slot_o,
  output logic                                evicted_valid_o,
  output logic [lrupr_pkg::PAGE_BITS-1:0]     evicted_page_o,
  output logic [lrupr_pkg::FAULT_W-1:0]       fault_count_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [lrupr_pkg::FRAMES_W-1:0]    frames_q;
  logic [lrupr_pkg::CNT_W-1:0]       n_act;
  logic [lrupr_pkg::FAULT_W-1:0]     faults_q;
  lrupr_pkg::chain_t                 head;
  lrupr_pkg::chain_t                 res_q;
  lrupr_pkg::chain_t                 cell_out [lrupr_pkg::MAX_FRAMES];
  lrupr_pkg::upd_t                   upd;
  logic                              reg_sel;
  logic                              finish;
  logic                              out_valid_q;
  logic                              hit_q;
  logic [lrupr_pkg::SLOT_W-1:0]      slot_q;
  logic                              ev_valid_q;
  logic [lrupr_pkg::PAGE_BITS-1:0]   ev_page_q;
  logic                              ev;
  logic [lrupr_pkg::IDX_W-1:0]       sel_slot;
  logic [lrupr_pkg::RANK_W-1:0]      sel_rank;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[lrupr_pkg::ADDR_W-1] == lrupr_pkg::REG_FRAMES_IN_USE);
  assign prdata  = reg_sel ? lrupr_pkg::DATA_W'(frames_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= lrupr_pkg::FRAMES_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      frames_q <= pwdata[lrupr_pkg::FRAMES_W-1:0];
    end
  end

  always_comb begin
    if (frames_q == '0) begin
      n_act = lrupr_pkg::CNT_W'(1);
    end else if (32'(frames_q) > lrupr_pkg::MAX_FRAMES) begin
      n_act = lrupr_pkg::CNT_W'(lrupr_pkg::MAX_FRAMES);
    end else begin
      n_act = lrupr_pkg::CNT_W'(frames_q);
    end
  end

  // Request entering the first cell.
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    head      = '0;
    head.tok  = in_valid_i && in_ready_o;
    head.page = page_i;
  end

  for (genvar k = 0; k < lrupr_pkg::MAX_FRAMES; k++) begin : g_cell
    lrupr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (lrupr_pkg::IDX_W'(k)),
      .n_act_i (n_act),
      .chain_i ((k == 0) ? head : cell_out[(k == 0) ? 0 : k - 1]),
      .chain_o (cell_out[k]),
      .upd_i   (upd)
    );
  end

  // Frame choice: hit frame, else lowest empty frame, else the oldest frame.
  always_comb begin
    ev = !res_q.found && !res_q.empty_found;
    if (res_q.found) begin
      sel_slot = res_q.found_idx;
      sel_rank = res_q.found_rank;
    end else if (res_q.empty_found) begin
      sel_slot = res_q.empty_idx;
      sel_rank = res_q.empty_rank;
    end else begin
      sel_slot = res_q.best_idx;
      sel_rank = res_q.best_rank;
    end
  end

  assign finish = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    upd.en   = finish;
    upd.fill = !res_q.found;
    upd.slot = sel_slot;
    upd.rank = sel_rank;
    upd.page = res_q.page;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (head.tok) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cell_out[lrupr_pkg::MAX_FRAMES-1].tok) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      faults_q    <= '0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_valid_q <= 1'b1;
        if (!res_q.found && faults_q != lrupr_pkg::FAULT_MAX) begin
          faults_q <= faults_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && cell_out[lrupr_pkg::MAX_FRAMES-1].tok) begin
      res_q <= cell_out[lrupr_pkg::MAX_FRAMES-1];
    end
    if (finish) begin
      hit_q      <= res_q.found;
      slot_q     <= lrupr_pkg::SLOT_W'(sel_slot);
      ev_valid_q <= ev;
      ev_page_q  <= ev ? res_q.best_page : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign slot_o          = slot_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = faults_q;

endmodule

@@ rtl/core/lrupr_checker.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Port-level properties of the replacement unit, bound to the top level.
// ----------------------------------------------------------------------------
module lrupr_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_o,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic                                hit_o,
  input  logic [lrupr_pkg::SLOT_W-1:0]        slot_o,
  input  logic                                evicted_valid_o,
  input  logic [lrupr_pkg::PAGE_BITS-1:0]     evicted_page_o,
  input  logic [lrupr_pkg::FAULT_W-1:0]       fault_count_o
);

  // An accepted item keeps the input closed while it walks the cells.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again right after an item");

  // A hit never evicts anything.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_valid_o)
    else $error("hit reported together with an eviction");

  // Without an eviction the evicted page reads as zero.
  a_no_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> evicted_page_o == '0)
    else $error("evicted page nonzero without an eviction");

  // A miss has been counted, so the fault count cannot be zero.
  a_miss_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> fault_count_o != '0)
    else $error("miss reported with a zero fault count");

  // A stalled result keeps its fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(slot_o) && $stable(hit_o) && $stable(fault_count_o))
    else $error("result changed while stalled");

endmodule

bind lru_page_replacement_unit lrupr_checker u_lrupr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .hit_o           (hit_o),
  .slot_o          (slot_o),
  .evicted_valid_o (evicted_valid_o),
  .evicted_page_o  (evicted_page_o),
  .fault_count_o   (fault_count_o)
);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement unit testbench
// Sends page references through the valid/ready input, predicts hit, frame,
// eviction and fault count for each one, and checks every result in order.
// The frame count is reprogrammed between bursts over its whole range.
// ----------------------------------------------------------------------------
module tb;
  import lrupr_pkg::*;

  localparam logic [ADDR_W-1:0] FRAMES_ADDR  = '0;
  localparam logic [ADDR_W-1:0] UNUSED_ADDR  = ADDR_W'(4);
  localparam int                ITEMS_CHUNK  = 100;
  localparam int                CHUNKS_PHASE = 4;
  localparam int                SETTLE_CYC   = MAX_FRAMES + 20;
  localparam int                MAX_REPORTS  = 20;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FAULT_W-1:0]   fault_count;
  } lookup_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [PAGE_BITS-1:0] page_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 hit_o;
  logic [SLOT_W-1:0]    slot_o;
  logic                 evicted_valid_o;
  logic [PAGE_BITS-1:0] evicted_page_o;
  logic [FAULT_W-1:0]   fault_count_o;

  lru_page_replacement_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .page_i         (page_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_count_o  (fault_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the frame set.
  logic [PAGE_BITS-1:0] frame_page [MAX_FRAMES];
  logic                 frame_full [MAX_FRAMES];
  logic [RANK_W-1:0]    frame_age  [MAX_FRAMES];
  logic [FAULT_W-1:0]   fault_tally;
  logic [FRAMES_W-1:0]  frames_cfg;

  logic [PAGE_BITS-1:0] pending_pages [$];
  lookup_t              lookups_due [$];
  logic [PAGE_BITS-1:0] page_pool [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int n_hits = 0;
  int n_evictions = 0;
  int n_errors = 0;

  function automatic int active_frames();
    int n;
    n = int'(frames_cfg);
    if (n < 1) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    return n;
  endfunction

  function automatic lookup_t lru_lookup(logic [PAGE_BITS-1:0] pg);
    lookup_t r;
    int      n;
    logic    found;
    logic    empty;
    int      victim_age;
    logic [RANK_W-1:0] old_age;
    n = active_frames();
    r = '0;
    found = 1'b0;
    empty = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && frame_full[i] && frame_page[i] == pg) begin
        r.slot = SLOT_W'(i);
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 0; i < n; i++) begin
        if (!empty && !frame_full[i]) begin
          r.slot = SLOT_W'(i);
          empty = 1'b1;
        end
      end
      if (!empty) begin
        // The oldest active frame; ranks are a permutation, so no ties.
        victim_age = -1;
        for (int i = 0; i < n; i++) begin
          if (int'(frame_age[i]) > victim_age) begin
            victim_age = int'(frame_age[i]);
            r.slot = SLOT_W'(i);
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_page = frame_page[r.slot];
      end
      frame_page[r.slot] = pg;
      frame_full[r.slot] = 1'b1;
      if (fault_tally != '1) fault_tally = fault_tally + 1'b1;
    end
    old_age = frame_age[r.slot];
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (frame_age[i] < old_age) frame_age[i] = frame_age[i] + 1'b1;
    end
    frame_age[r.slot] = '0;
    r.hit = found;
    r.fault_count = fault_tally;
    return r;
  endfunction

  // Driver: presents queued references, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      page_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        lookups_due.push_back(lru_lookup(page_i));
        n_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_pages.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i <= 1'b1;
          page_i <= pending_pages.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Monitor: stalls the result side at random and checks each result.
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (lookups_due.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual slot %0d", $time,
                     slot_o);
        end else begin
          want = lookups_due.pop_front();
          check_field("hit", want.hit, hit_o);
          check_field("slot", want.slot, slot_o);
          check_field("evicted_valid", want.evicted_valid, evicted_valid_o);
          check_field("evicted_page", want.evicted_page, evicted_page_o);
          check_field("fault_count", want.fault_count, fault_count_o);
          n_checked++;
          if (want.hit) n_hits++;
          if (want.evicted_valid) n_evictions++;
        end
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr[ADDR_W-1:2] == REG_FRAMES_IN_USE) frames_cfg = data[FRAMES_W-1:0];
    n_cfg++;
  endtask

  // Blocks until every queued item is accepted and every result has come.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_pages.size() != 0 || in_valid_i || lookups_due.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  function automatic logic [PAGE_BITS-1:0] pick_page();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return (roll < 2) ? '0 : '1;
    if (roll < 14 || page_pool.size() == 0) return PAGE_BITS'($urandom);
    return page_pool[$urandom_range(page_pool.size() - 1)];
  endfunction

  task automatic queue_burst(input int count);
    int pool_n;
    pool_n = $urandom_range(1, 2 * active_frames() + 4);
    page_pool.delete();
    for (int i = 0; i < pool_n; i++) page_pool.push_back(PAGE_BITS'($urandom));
    @(negedge clk_i);
    for (int i = 0; i < count; i++) pending_pages.push_back(pick_page());
  endtask

  task automatic queue_pages(input logic [PAGE_BITS-1:0] pages [$]);
    @(negedge clk_i);
    foreach (pages[i]) pending_pages.push_back(pages[i]);
  endtask

  initial begin
    logic [PAGE_BITS-1:0] seq [$];
    int                   pick;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      frame_page[i] = '0;
      frame_full[i] = 1'b0;
      frame_age[i] = RANK_W'(i);
    end
    fault_tally = '0;
    frames_cfg = FRAMES_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: page 0 against the zeroed frames, fills, hits and evictions.
    seq = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'hFFFF};
    queue_pages(seq);
    wait_drained();
    cfg_write(UNUSED_ADDR, 32'd1);
    cfg_write(FRAMES_ADDR, 32'd0);
    seq = '{16'h5555, 16'hAAAA};
    queue_pages(seq);
    wait_drained();
    cfg_write(FRAMES_ADDR, 32'd31);
    seq.delete();
    for (int i = 0; i < 12; i++) seq.push_back(PAGE_BITS'(100 + i));
    queue_pages(seq);
    wait_drained();
    // Shrink, pull a page held in a high frame into a low one, then regrow so
    // that the page is resident twice.
    cfg_write(FRAMES_ADDR, 32'd2);
    seq = '{16'd110};
    queue_pages(seq);
    wait_drained();
    cfg_write(FRAMES_ADDR, 32'd17);
    queue_pages(seq);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 81 : 0;
      rx_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 6 : 0;
      for (int c = 0; c < CHUNKS_PHASE; c++) begin
        pick = $urandom_range(7);
        case (pick)
          0: cfg_write(FRAMES_ADDR, 32'd1);
          1: cfg_write(FRAMES_ADDR, 32'd16);
          2: cfg_write(FRAMES_ADDR, 32'd0);
          3: cfg_write(FRAMES_ADDR, 32'd31);
          default: cfg_write(FRAMES_ADDR, DATA_W'($urandom_range(31)));
        endcase
        queue_burst(ITEMS_CHUNK);
        wait_drained();
      end
    end

    $display("Checked %0d of %0d references (%0d hits, %0d evictions), %0d register writes.",
             n_checked, n_sent, n_hits, n_evictions, n_cfg);
    $display("Frame counts 0 to 31 with clamping, duplicate residents, fault count %0d.",
             fault_tally);
    if (n_errors == 0 && lookups_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Timed out with %0d results outstanding.", lookups_due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/lrupr_pkg.sv
rtl/core/lrupr_cell.sv
rtl/core/lru_page_replacement_unit.sv
rtl/core/lrupr_checker.sv
tb/sv/tb.sv
